// File: hw/rtl/tarc_pkg.sv
// Shared types and constants of the tile atlas rectangle calculator.
`timescale 1ns / 1ps
`default_nettype none
package tarc_pkg;

  localparam int unsigned MarginRightDef  = 0;
  localparam int unsigned MarginBottomDef = 0;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COLUMN_COUNT = 3'd2,
    REG_ROW_COUNT    = 3'd3,
    REG_MARGIN_LEFT  = 3'd4,
    REG_MARGIN_TOP   = 3'd5,
    REG_GAP_HORIZ    = 3'd6,
    REG_GAP_VERT     = 3'd7
  } tarc_reg_e;

  typedef struct packed {
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [10:0] column_count;
    logic [10:0] row_count;
    logic [11:0] margin_left;
    logic [11:0] margin_top;
    logic [11:0] gap_horizontal;
    logic [11:0] gap_vertical;
  } tarc_cfg_t;

  // Values derived from the registers, worked out once after every write.
  typedef struct packed {
    logic [31:0] rcp_col;
    logic [31:0] rcp_w;
    logic [31:0] rcp_h;
    logic [14:0] tile_w;
    logic [14:0] tile_h;
    logic        size_ok;
  } tarc_drv_t;

endpackage
`default_nettype wire

// File: hw/rtl/tile_atlas_rect_calc.sv
// Top level of the tile atlas rectangle calculator.
// Eight-stage pipeline that takes one request per cycle unless stalled or busy;
// quotients come from reciprocal multiplies with one correction step.
// After reset and after every register write a shared bit-serial divider derives the
// tile sizes and three reciprocals; while it runs, in_ready_o stays low. A stalled
// output holds the whole pipeline without losing any request.
`timescale 1ns / 1ps
`default_nettype none
module tile_atlas_rect_calc import tarc_pkg::*; #(
  parameter int unsigned MARGIN_RIGHT  = MarginRightDef,
  parameter int unsigned MARGIN_BOTTOM = MarginBottomDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                action_i,
  input  wire logic [19:0]         tile_index_i,
  input  wire logic [9:0]          tile_col_in_i,
  input  wire logic [9:0]          tile_row_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     invalid_o,
  output logic [19:0]              linear_index_o,
  output logic [9:0]               tile_col_o,
  output logic [9:0]               tile_row_o,
  output logic [14:0]              min_x_o,
  output logic [14:0]              min_y_o,
  output logic [14:0]              max_x_o,
  output logic [14:0]              max_y_o,
  output logic [16:0]              u_min_o,
  output logic [16:0]              v_min_o,
  output logic [16:0]              u_max_o,
  output logic [16:0]              v_max_o
);

  tarc_cfg_t cfg_q;
  tarc_drv_t drv;
  logic      busy;
  logic      en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= 15'd1;
      cfg_q.image_height   <= 15'd1;
      cfg_q.column_count   <= 11'd1;
      cfg_q.row_count      <= 11'd1;
      cfg_q.margin_left    <= '0;
      cfg_q.margin_top     <= '0;
      cfg_q.gap_horizontal <= '0;
      cfg_q.gap_vertical   <= '0;
    end else if (cfg_we_i) begin
      unique case (tarc_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  cfg_q.image_width    <= cfg_data_i;
        REG_IMAGE_HEIGHT: cfg_q.image_height   <= cfg_data_i;
        REG_COLUMN_COUNT: cfg_q.column_count   <= cfg_data_i[10:0];
        REG_ROW_COUNT:    cfg_q.row_count      <= cfg_data_i[10:0];
        REG_MARGIN_LEFT:  cfg_q.margin_left    <= cfg_data_i[11:0];
        REG_MARGIN_TOP:   cfg_q.margin_top     <= cfg_data_i[11:0];
        REG_GAP_HORIZ:    cfg_q.gap_horizontal <= cfg_data_i[11:0];
        REG_GAP_VERT:     cfg_q.gap_vertical   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  tarc_cfg_unit #(
    .MARGIN_RIGHT (MARGIN_RIGHT),
    .MARGIN_BOTTOM(MARGIN_BOTTOM)
  ) u_cfg_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(cfg_we_i),
    .cfg_i    (cfg_q),
    .drv_o    (drv),
    .busy_o   (busy)
  );

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && !busy;

  // Stage valid bits.
  logic [7:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:1], in_valid_i && in_ready_o};
    end
  end

  // Stage 1: estimate index / column_count.
  logic        act1_q;
  logic [19:0] idx1_q, qe1_q;
  logic [9:0]  ci1_q, ri1_q;
  logic [51:0] prod1;
  assign prod1 = tile_index_i * drv.rcp_col;

  // Stage 2: remainder of the estimate.
  logic        act2_q;
  logic [19:0] q2_q;
  logic [11:0] r2_q;
  logic [9:0]  ci2_q, ri2_q;
  logic [30:0] prod2;
  assign prod2 = qe1_q * cfg_q.column_count;

  // Stage 3: correction, coordinate select and grid check.
  logic        inv3_q;
  logic [10:0] col3_q, row3_q;
  logic        fix3;
  logic [10:0] col3;
  logic [19:0] row3;
  always_comb begin
    fix3 = r2_q >= {1'b0, cfg_q.column_count};
    if (act2_q) begin
      col3 = {1'b0, ci2_q};
      row3 = {10'd0, ri2_q};
    end else begin
      col3 = fix3 ? 11'(r2_q - {1'b0, cfg_q.column_count}) : r2_q[10:0];
      row3 = fix3 ? q2_q + 20'd1 : q2_q;
    end
  end

  // Stage 4: linear index and min corner.
  logic        inv4_q;
  logic [10:0] col4_q, row4_q;
  logic [19:0] lin4_q;
  logic [14:0] x0_4_q, y0_4_q;
  logic [15:0] step_x, step_y;
  logic [26:0] off_x, off_y;
  always_comb begin
    step_x = {1'b0, drv.tile_w} + {4'd0, cfg_q.gap_horizontal};
    step_y = {1'b0, drv.tile_h} + {4'd0, cfg_q.gap_vertical};
    off_x  = col3_q * step_x;
    off_y  = row3_q * step_y;
  end

  // Stage 5: max corner.
  logic        inv5_q;
  logic [10:0] col5_q, row5_q;
  logic [19:0] lin5_q;
  logic [14:0] crn5_q [4];

  // Stages 6 to 8: four corner fractions.
  logic        inv6_q, inv7_q;
  logic [10:0] col6_q, row6_q, col7_q, row7_q;
  logic [19:0] lin6_q, lin7_q;
  logic [14:0] crn6_q [4];
  logic [14:0] crn7_q [4];
  logic [16:0] qe6_q [4];
  logic [16:0] qe7_q [4];
  logic [16:0] rem7_q [4];
  logic [16:0] frac [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q <= action_i;
      idx1_q <= tile_index_i;
      ci1_q  <= tile_col_in_i;
      ri1_q  <= tile_row_in_i;
      qe1_q  <= prod1[51:32];

      act2_q <= act1_q;
      q2_q   <= qe1_q;
      r2_q   <= 12'(idx1_q - prod2[19:0]);
      ci2_q  <= ci1_q;
      ri2_q  <= ri1_q;

      inv3_q <= (cfg_q.column_count == 11'd0) || (cfg_q.row_count == 11'd0) || !drv.size_ok
             || (col3 >= cfg_q.column_count) || (row3 >= {9'd0, cfg_q.row_count});
      col3_q <= col3;
      row3_q <= row3[10:0];

      inv4_q <= inv3_q;
      col4_q <= col3_q;
      row4_q <= row3_q;
      lin4_q <= 20'(row3_q * cfg_q.column_count + {11'd0, col3_q});
      x0_4_q <= 15'(off_x + {15'd0, cfg_q.margin_left});
      y0_4_q <= 15'(off_y + {15'd0, cfg_q.margin_top});

      inv5_q    <= inv4_q;
      col5_q    <= col4_q;
      row5_q    <= row4_q;
      lin5_q    <= lin4_q;
      crn5_q[0] <= x0_4_q;
      crn5_q[1] <= y0_4_q;
      crn5_q[2] <= x0_4_q + drv.tile_w;
      crn5_q[3] <= y0_4_q + drv.tile_h;

      inv6_q <= inv5_q;
      col6_q <= col5_q;
      row6_q <= row5_q;
      lin6_q <= lin5_q;
      crn6_q <= crn5_q;

      inv7_q <= inv6_q;
      col7_q <= col6_q;
      row7_q <= row6_q;
      lin7_q <= lin6_q;
      crn7_q <= crn6_q;
      qe7_q  <= qe6_q;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_frac
    logic [31:0] rcp;
    logic [14:0] size;
    logic [46:0] prod_q;
    logic [31:0] prod_r;
    assign rcp    = (g % 2 == 0) ? drv.rcp_w : drv.rcp_h;
    assign size   = (g % 2 == 0) ? cfg_q.image_width : cfg_q.image_height;
    assign prod_q = crn5_q[g] * rcp;
    assign prod_r = qe6_q[g] * size;
    assign frac[g] = (rem7_q[g] >= {2'd0, size}) ? qe7_q[g] + 17'd1 : qe7_q[g];

    always_ff @(posedge clk_i) begin
      if (en) begin
        qe6_q[g]  <= prod_q[32:16];
        rem7_q[g] <= 17'({1'b0, crn6_q[g], 16'd0} - prod_r);
      end
    end
  end

  // Stage 8: output register, cleared fields for a rejected request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= v_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      invalid_o      <= inv7_q;
      linear_index_o <= inv7_q ? '0 : lin7_q;
      tile_col_o     <= inv7_q ? '0 : col7_q[9:0];
      tile_row_o     <= inv7_q ? '0 : row7_q[9:0];
      min_x_o        <= inv7_q ? '0 : crn7_q[0];
      min_y_o        <= inv7_q ? '0 : crn7_q[1];
      max_x_o        <= inv7_q ? '0 : crn7_q[2];
      max_y_o        <= inv7_q ? '0 : crn7_q[3];
      u_min_o        <= inv7_q ? '0 : frac[0];
      v_min_o        <= inv7_q ? '0 : frac[1];
      u_max_o        <= inv7_q ? '0 : frac[2];
      v_max_o        <= inv7_q ? '0 : frac[3];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tarc_cfg_unit.sv
// Sequential divider that derives tile sizes and reciprocals from the registers.
`timescale 1ns / 1ps
`default_nettype none
module tarc_cfg_unit import tarc_pkg::*; #(
  parameter int unsigned MARGIN_RIGHT  = MarginRightDef,
  parameter int unsigned MARGIN_BOTTOM = MarginBottomDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      restart_i,
  input  wire tarc_cfg_t cfg_i,
  output tarc_drv_t      drv_o,
  output logic           busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    OP_RCP_COL = 3'd0,
    OP_RCP_W   = 3'd1,
    OP_RCP_H   = 3'd2,
    OP_TILE_W  = 3'd3,
    OP_TILE_H  = 3'd4
  } op_e;

  localparam logic [11:0] MarginR = 12'(MARGIN_RIGHT);
  localparam logic [11:0] MarginB = 12'(MARGIN_BOTTOM);

  state_e      state_q, state_d;
  op_e         op_q, op_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [14:0] dsr_q, dsr_d;
  logic [14:0] rem_q, rem_d;
  logic [14:0] num_x_q, num_y_q;
  logic        ok_q;
  tarc_drv_t   drv_q, drv_d;

  logic signed [24:0] num_x, num_y;
  logic        ok_x, ok_y;
  logic [15:0] rem_sh;
  logic        ge;
  logic [31:0] ld_dvd;
  logic [14:0] ld_dsr;

  // Space left for the tiles once margins and gaps are taken off.
  always_comb begin
    num_x = $signed({10'd0, cfg_i.image_width}) - $signed({13'd0, cfg_i.margin_left})
          - $signed({13'd0, MarginR})
          - $signed({2'd0, 23'(cfg_i.gap_horizontal * (cfg_i.column_count - 11'd1))});
    num_y = $signed({10'd0, cfg_i.image_height}) - $signed({13'd0, cfg_i.margin_top})
          - $signed({13'd0, MarginB})
          - $signed({2'd0, 23'(cfg_i.gap_vertical * (cfg_i.row_count - 11'd1))});
    ok_x = (cfg_i.column_count != 11'd0) && (num_x >= $signed({14'd0, cfg_i.column_count}));
    ok_y = (cfg_i.row_count != 11'd0) && (num_y >= $signed({14'd0, cfg_i.row_count}));
  end

  always_comb begin
    rem_sh = {rem_q, dvd_q[31]};
    ge     = rem_sh >= {1'b0, dsr_q};
  end

  always_comb begin
    unique case (op_d)
      OP_RCP_COL: begin ld_dvd = '1; ld_dsr = {4'd0, cfg_i.column_count}; end
      OP_RCP_W:   begin ld_dvd = '1; ld_dsr = cfg_i.image_width; end
      OP_RCP_H:   begin ld_dvd = '1; ld_dsr = cfg_i.image_height; end
      OP_TILE_W:  begin ld_dvd = {17'd0, num_x_q}; ld_dsr = {4'd0, cfg_i.column_count}; end
      OP_TILE_H:  begin ld_dvd = {17'd0, num_y_q}; ld_dsr = {4'd0, cfg_i.row_count}; end
      default:    begin ld_dvd = '1; ld_dsr = '1; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    drv_d   = drv_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_PREP: begin
        op_d    = OP_RCP_COL;
        state_d = ST_DIV;
        cnt_d   = '0;
        rem_d   = '0;
        dvd_d   = ld_dvd;
        dsr_d   = ld_dsr;
      end
      ST_DIV: begin
        rem_d = ge ? 15'(rem_sh - {1'b0, dsr_q}) : rem_sh[14:0];
        dvd_d = {dvd_q[30:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          unique case (op_q)
            OP_RCP_COL: drv_d.rcp_col = dvd_d;
            OP_RCP_W:   drv_d.rcp_w   = dvd_d;
            OP_RCP_H:   drv_d.rcp_h   = dvd_d;
            OP_TILE_W:  drv_d.tile_w  = dvd_d[14:0];
            OP_TILE_H:  drv_d.tile_h  = dvd_d[14:0];
            default: ;
          endcase
          drv_d.size_ok = ok_q;
          if (op_q == OP_TILE_H) begin
            state_d = ST_IDLE;
          end else begin
            op_d  = op_e'(op_q + 3'd1);
            rem_d = '0;
            dvd_d = ld_dvd;
            dsr_d = ld_dsr;
          end
        end
      end
      default: state_d = ST_PREP;
    endcase
    if (restart_i) state_d = ST_PREP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREP;
      op_q    <= OP_RCP_COL;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    drv_q <= drv_d;
    if (state_q == ST_PREP) begin
      num_x_q <= num_x[14:0];
      num_y_q <= num_y[14:0];
      ok_q    <= ok_x && ok_y;
    end
  end

  assign drv_o  = drv_q;
  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire
